// File: hw/rtl/mtkte_pkg.sv
// Shared types, codes and character tables of the multi-tap keypad text entry block.
// Depends on nothing; the top level imports it.
package mtkte_pkg;

  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_LONG  = 2'd1,
    EV_TICK  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_DELETE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CM_UPPER = 2'd0,
    CM_LOWER = 2'd1,
    CM_DIGIT = 2'd2
  } case_mode_e;

  typedef enum logic [1:0] {
    CFG_MAX_LENGTH   = 2'd0,
    CFG_START_LENGTH = 2'd1,
    CFG_COMMIT_TICKS = 2'd2
  } cfg_index_e;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_SHIFT      = 4'd10;
  localparam logic [3:0] KEY_BACK       = 4'd11;
  localparam logic [3:0] KEY_NONE       = 4'd12;

  localparam logic [7:0] MAX_LENGTH_RESET   = 8'd255;
  localparam logic [7:0] START_LENGTH_RESET = 8'd0;
  localparam logic [7:0] COMMIT_TICKS_RESET = 8'd80;
  localparam logic [7:0] DIGIT_BASE         = 8'h30;

  // Last valid cycle index for each digit key.
  localparam logic [2:0] KEY_LAST_IDX [10] = '{
    3'd0, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam logic [7:0] UPPER_TAB [10][5] = '{
    '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2E, 8'h2C, 8'h3F, 8'h21, 8'h31},
    '{8'h80, 8'h81, 8'h82, 8'h83, 8'h12},
    '{8'h84, 8'h85, 8'h86, 8'h87, 8'h13},
    '{8'h88, 8'h89, 8'h8A, 8'h8B, 8'h14},
    '{8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h15},
    '{8'h90, 8'h91, 8'h92, 8'h93, 8'h16},
    '{8'h94, 8'h95, 8'h96, 8'h97, 8'h17},
    '{8'h98, 8'h99, 8'h9A, 8'h9B, 8'h18},
    '{8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'h19}
  };

  localparam logic [7:0] LOWER_TAB [10][5] = '{
    '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2E, 8'h2C, 8'h3F, 8'h21, 8'h31},
    '{8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'h12},
    '{8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'h13},
    '{8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'h14},
    '{8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'h15},
    '{8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'h16},
    '{8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'h17},
    '{8'hE8, 8'hE9, 8'hEA, 8'hEB, 8'h18},
    '{8'hEC, 8'hED, 8'hEE, 8'hEF, 8'h19}
  };

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic       handled;
    logic [1:0] edit_action;
    logic [7:0] char_code;
    logic [7:0] write_position;
    logic [7:0] new_length;
    logic [1:0] case_mode;
  } out_item_t;

endpackage

// File: hw/rtl/multitap_keypad_text_entry.sv
// Multi-tap keypad text entry editor: top level with input and result registers.
// Depends on mtkte_pkg for the payload structs, codes and character tables.
//
// Each accepted event transaction is held in an input register, and its single result
// transaction is loaded into the result register once that register is empty or its
// output is not stalled, and is offered from there. One event is taken every cycle while
// the output is not stalled; the rate is set by the single state-update step between the
// two registers, and the result register lets a new event enter while a finished result
// still waits. Configuration writes take effect at once and restart editing when
// max_length or start_length is written.
module multitap_keypad_text_entry
  import mtkte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  logic       in_valid_q, in_valid_d;
  in_item_t   in_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, res;
  logic       advance, in_accept;

  logic [7:0] max_len_q, max_len_d;
  logic [7:0] start_len_q, start_len_d;
  logic [7:0] commit_q, commit_d;
  logic [7:0] len_q, len_d;
  case_mode_e cmode_q, cmode_d;
  logic       pend_q, pend_d;
  logic [3:0] pkey_q, pkey_d;
  logic [2:0] cpos_q, cpos_d;
  logic [7:0] idle_q, idle_d;

  logic [3:0] key;
  logic       is_digit;
  logic [7:0] digit_char;
  logic [2:0] next_cpos;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !advance;
  assign in_valid_d = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  assign key        = in_q.key_code;
  assign is_digit   = (key <= KEY_LAST_DIGIT);
  assign digit_char = DIGIT_BASE + {4'd0, key};
  assign next_cpos  = (is_digit && (cpos_q < KEY_LAST_IDX[key])) ? cpos_q + 3'd1 : 3'd0;

  always_comb begin
    max_len_d   = max_len_q;
    start_len_d = start_len_q;
    commit_d    = commit_q;
    len_d       = len_q;
    cmode_d     = cmode_q;
    pend_d      = pend_q;
    pkey_d      = pkey_q;
    cpos_d      = cpos_q;
    idle_d      = idle_q;
    res         = '0;

    if (in_valid_q && advance) begin
      case (event_e'(in_q.mode))
        EV_TICK: begin
          if (pend_q) begin
            idle_d = idle_q + 8'd1;
            if (idle_d >= commit_q) begin
              pend_d = 1'b0;
              pkey_d = KEY_NONE;
              cpos_d = 3'd0;
              idle_d = 8'd0;
            end
          end
        end
        EV_LONG: begin
          if (is_digit) begin
            res.handled = 1'b1;
            pend_d = 1'b0;
            pkey_d = KEY_NONE;
            cpos_d = 3'd0;
            idle_d = 8'd0;
            if (len_q < max_len_q) begin
              res.edit_action    = ACT_APPEND;
              res.char_code      = digit_char;
              res.write_position = len_q;
              len_d              = len_q + 8'd1;
            end
          end
        end
        EV_SHORT: begin
          if (key == KEY_SHIFT) begin
            res.handled = 1'b1;
            pend_d = 1'b0;
            pkey_d = KEY_NONE;
            cpos_d = 3'd0;
            idle_d = 8'd0;
            case (cmode_q)
              CM_UPPER: cmode_d = CM_LOWER;
              CM_LOWER: cmode_d = CM_DIGIT;
              default:  cmode_d = CM_UPPER;
            endcase
          end else if (key == KEY_BACK) begin
            res.handled = 1'b1;
            pend_d = 1'b0;
            pkey_d = KEY_NONE;
            cpos_d = 3'd0;
            idle_d = 8'd0;
            if (len_q != 8'd0) begin
              len_d              = len_q - 8'd1;
              res.edit_action    = ACT_DELETE;
              res.write_position = len_d;
            end
          end else if (is_digit) begin
            res.handled = 1'b1;
            if (cmode_q == CM_DIGIT) begin
              pend_d = 1'b0;
              pkey_d = KEY_NONE;
              cpos_d = 3'd0;
              idle_d = 8'd0;
              if (len_q < max_len_q) begin
                res.edit_action    = ACT_APPEND;
                res.char_code      = digit_char;
                res.write_position = len_q;
                len_d              = len_q + 8'd1;
              end
            end else if (pend_q && (pkey_q == key) && (len_q != 8'd0)) begin
              cpos_d             = next_cpos;
              idle_d             = 8'd0;
              res.edit_action    = ACT_REPLACE;
              res.char_code      = (cmode_q == CM_LOWER) ? LOWER_TAB[key][next_cpos]
                                                         : UPPER_TAB[key][next_cpos];
              res.write_position = len_q - 8'd1;
            end else begin
              pend_d = 1'b0;
              pkey_d = KEY_NONE;
              cpos_d = 3'd0;
              idle_d = 8'd0;
              if (len_q < max_len_q) begin
                pend_d             = 1'b1;
                pkey_d             = key;
                res.edit_action    = ACT_APPEND;
                res.char_code      = (cmode_q == CM_LOWER) ? LOWER_TAB[key][0]
                                                           : UPPER_TAB[key][0];
                res.write_position = len_q;
                len_d              = len_q + 8'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.new_length = len_d;
    res.case_mode  = cmode_d;

    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MAX_LENGTH:   max_len_d   = cfg_data_i;
        CFG_START_LENGTH: start_len_d = cfg_data_i;
        CFG_COMMIT_TICKS: commit_d    = cfg_data_i;
        default: begin
        end
      endcase
      if ((cfg_index_i == CFG_MAX_LENGTH) || (cfg_index_i == CFG_START_LENGTH)) begin
        len_d   = (start_len_d > max_len_d) ? max_len_d : start_len_d;
        cmode_d = CM_UPPER;
        pend_d  = 1'b0;
        pkey_d  = KEY_NONE;
        cpos_d  = 3'd0;
        idle_d  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_len_q   <= MAX_LENGTH_RESET;
      start_len_q <= START_LENGTH_RESET;
      commit_q    <= COMMIT_TICKS_RESET;
      len_q       <= START_LENGTH_RESET;
      cmode_q     <= CM_UPPER;
      pend_q      <= 1'b0;
      pkey_q      <= KEY_NONE;
      cpos_q      <= 3'd0;
      idle_q      <= 8'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      max_len_q   <= max_len_d;
      start_len_q <= start_len_d;
      commit_q    <= commit_d;
      len_q       <= len_d;
      cmode_q     <= cmode_d;
      pend_q      <= pend_d;
      pkey_q      <= pkey_d;
      cpos_q      <= cpos_d;
      idle_q      <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (in_valid_q && advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= max_len_q)
    else $error("text length exceeds max_length");

  a_no_pending_in_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (cmode_q != CM_DIGIT))
    else $error("pending character while in digits mode");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> (pkey_q == KEY_NONE && cpos_q == 3'd0 && idle_q == 8'd0))
    else $error("stale multi-tap state without pending character");

  a_cpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cpos_q <= 3'd4)
    else $error("cycle index out of range");

  a_append_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.edit_action == ACT_APPEND)
      |-> (out_q.new_length == out_q.write_position + 8'd1))
    else $error("append result length mismatch");

endmodule

// File: verif/tb_multitap_keypad_text_entry.sv
// Self-checking testbench for the multi-tap keypad text entry editor.
// It predicts every edit from a model of its own and checks it under random stalls.
// Depends on mtkte_pkg and multitap_keypad_text_entry.
`timescale 1ns / 100ps

module tb_multitap_keypad_text_entry;
  import mtkte_pkg::*;

  localparam logic [1:0] EV_UNUSED = 2'd3;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 200;
  localparam logic [7:0] PH_MAX [N_PHASES] = '{
    8'd255, 8'd0, 8'd10, 8'd255, 8'd5, 8'd40, 8'd255, 8'd1
  };
  localparam logic [7:0] PH_START [N_PHASES] = '{
    8'd0, 8'd0, 8'd200, 8'd255, 8'd3, 8'd20, 8'd250, 8'd0
  };
  localparam logic [7:0] PH_TICKS [N_PHASES] = '{
    8'd3, 8'd1, 8'd2, 8'd0, 8'd255, 8'd80, 8'd4, 8'd1
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;

  in_item_t  key_events [$];
  out_item_t exp_edits [$];
  logic      in_taken = 1'b0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  logic      long_hold_arm = 1'b0;
  int        long_hold_left = 0;
  int        fail_cnt = 0;
  int        events_taken = 0;
  int        events_queued = 0;
  int        action_cnt [4] = '{0, 0, 0, 0};

  // Predictor copy of the registers and the editor state.
  logic [7:0] lim_len, base_len, commit_lim;
  logic [7:0] txt_len, idle_cnt;
  case_mode_e ent_mode;
  logic       pend;
  logic [3:0] pend_key;
  logic [2:0] cyc_pos;

  multitap_keypad_text_entry DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_pending();
    pend = 1'b0;
    pend_key = KEY_NONE;
    cyc_pos = '0;
    idle_cnt = '0;
  endfunction

  function automatic void restart_text();
    txt_len = (base_len > lim_len) ? lim_len : base_len;
    ent_mode = CM_UPPER;
    drop_pending();
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [7:0] val);
    case (cfg_index_e'(idx))
      CFG_MAX_LENGTH: begin
        lim_len = val;
        restart_text();
      end
      CFG_START_LENGTH: begin
        base_len = val;
        restart_text();
      end
      CFG_COMMIT_TICKS: commit_lim = val;
      default: ;
    endcase
  endfunction

  // Character of a digit key at a cycle index in upper or lower case.
  function automatic logic [7:0] glyph(case_mode_e cm, logic [3:0] key, logic [2:0] idx);
    logic [7:0] punct [5];
    logic [7:0] base;
    punct = '{8'h2E, 8'h2C, 8'h3F, 8'h21, 8'h31};
    if (key == 4'd0) return (idx == 3'd0) ? 8'h20 : 8'h00;
    if (key == 4'd1) return punct[idx];
    if (idx == 3'd4) return 8'h10 + key;
    if (cm == CM_LOWER) begin
      base = (key < 4'd6) ? 8'(8'hA0 + 4 * (int'(key) - 2))
                          : 8'(8'hE0 + 4 * (int'(key) - 6));
    end else begin
      base = 8'(8'h80 + 4 * (int'(key) - 2));
    end
    return base + idx;
  endfunction

  function automatic out_item_t append_char(out_item_t r, logic [7:0] ch);
    out_item_t o;
    o = r;
    if (txt_len < lim_len) begin
      o.edit_action = ACT_APPEND;
      o.char_code = ch;
      o.write_position = txt_len;
      txt_len = txt_len + 8'd1;
    end
    return o;
  endfunction

  function automatic out_item_t predict_edit(in_item_t ev);
    out_item_t r;
    r = '0;
    if (ev.mode == EV_TICK) begin
      if (pend) begin
        idle_cnt = idle_cnt + 8'd1;
        if (idle_cnt >= commit_lim) drop_pending();
      end
    end else if (ev.mode == EV_LONG) begin
      if (ev.key_code <= KEY_LAST_DIGIT) begin
        r.handled = 1'b1;
        drop_pending();
        r = append_char(r, DIGIT_BASE + ev.key_code);
      end
    end else if (ev.mode == EV_SHORT) begin
      if (ev.key_code == KEY_SHIFT) begin
        r.handled = 1'b1;
        drop_pending();
        ent_mode = (ent_mode == CM_DIGIT) ? CM_UPPER : case_mode_e'(ent_mode + 2'd1);
      end else if (ev.key_code == KEY_BACK) begin
        r.handled = 1'b1;
        if (txt_len > 0) begin
          txt_len = txt_len - 8'd1;
          r.edit_action = ACT_DELETE;
          r.write_position = txt_len;
        end
        drop_pending();
      end else if (ev.key_code <= KEY_LAST_DIGIT) begin
        r.handled = 1'b1;
        if (ent_mode == CM_DIGIT) begin
          drop_pending();
          r = append_char(r, DIGIT_BASE + ev.key_code);
        end else if (pend && pend_key == ev.key_code && txt_len > 0) begin
          cyc_pos = (ev.key_code == 4'd0 || cyc_pos == 3'd4) ? 3'd0 : cyc_pos + 3'd1;
          r.edit_action = ACT_REPLACE;
          r.char_code = glyph(ent_mode, ev.key_code, cyc_pos);
          r.write_position = txt_len - 8'd1;
          idle_cnt = '0;
        end else begin
          drop_pending();
          if (txt_len < lim_len) begin
            pend = 1'b1;
            pend_key = ev.key_code;
            r = append_char(r, glyph(ent_mode, ev.key_code, 3'd0));
          end
        end
      end
    end
    r.new_length = txt_len;
    r.case_mode = ent_mode;
    return r;
  endfunction

  function automatic void add_event(logic [1:0] m, logic [3:0] k);
    in_item_t it;
    it.mode = m;
    it.key_code = k;
    key_events.push_back(it);
    events_queued++;
  endfunction

  // Queues one random group of events and returns how many of them count as real work.
  function automatic int queue_burst();
    int kind, n;
    logic [3:0] k;
    kind = $urandom_range(99);
    k = 4'($urandom_range(9));
    if (kind < 40) begin
      n = $urandom_range(1, 7);
      repeat (n) add_event(EV_SHORT, k);
    end else if (kind < 55) begin
      if ($urandom_range(2) == 0 && (commit_lim <= 20 || $urandom_range(9) == 0)) begin
        n = int'(commit_lim) + 1;
      end else begin
        n = $urandom_range(1, 3);
      end
      repeat (n) add_event(EV_TICK, 4'($urandom_range(15)));
    end else if (kind < 65) begin
      n = 1;
      add_event(EV_SHORT, KEY_SHIFT);
    end else if (kind < 75) begin
      n = $urandom_range(1, 3);
      repeat (n) add_event(EV_SHORT, KEY_BACK);
    end else if (kind < 85) begin
      n = 1;
      add_event(EV_LONG, k);
    end else begin
      n = 0;
      add_event(2'($urandom_range(3)), 4'($urandom_range(15)));
    end
    return n;
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (events_taken != events_queued) @(negedge clk_i);
    while (exp_edits.size() != 0 && waited < 3000) begin
      @(negedge clk_i);
      waited++;
    end
    if (exp_edits.size() != 0) begin
      fail_cnt += exp_edits.size();
      $display("%0d expected edits never arrived", exp_edits.size());
      exp_edits.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (key_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= key_events.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_arm) begin
      long_hold_left = HOLD_CYCLES;
      long_hold_arm = 1'b0;
    end
    if (long_hold_left > 0) begin
      out_stall_i <= 1'b1;
      long_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        exp_edits.push_back(predict_edit(in_data_i));
        events_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (exp_edits.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected edit transaction %h", out_data_o);
        end else begin
          want = exp_edits.pop_front();
          action_cnt[want.edit_action]++;
          if (out_data_o.handled !== want.handled
              || out_data_o.edit_action !== want.edit_action
              || out_data_o.char_code !== want.char_code
              || out_data_o.write_position !== want.write_position
              || out_data_o.new_length !== want.new_length
              || out_data_o.case_mode !== want.case_mode) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("edit mismatch at %0t: exp h=%0d act=%0d ch=%h pos=%0d len=%0d cm=%0d",
                       $realtime, want.handled, want.edit_action, want.char_code,
                       want.write_position, want.new_length, want.case_mode);
              $display("                     got h=%0d act=%0d ch=%h pos=%0d len=%0d cm=%0d",
                       out_data_o.handled, out_data_o.edit_action, out_data_o.char_code,
                       out_data_o.write_position, out_data_o.new_length, out_data_o.case_mode);
            end
          end
        end
      end
    end
  end

  initial begin
    int counted;
    lim_len = MAX_LENGTH_RESET;
    base_len = START_LENGTH_RESET;
    commit_lim = COMMIT_TICKS_RESET;
    restart_text();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 25;
    rx_stall_pct = 77;

    // A key cycled past its table end, the one-entry space key, then other keys.
    repeat (6) add_event(EV_SHORT, 4'd2);
    repeat (2) add_event(EV_SHORT, 4'd0);
    add_event(EV_SHORT, 4'd1);
    add_event(EV_SHORT, KEY_BACK);
    add_event(EV_LONG, 4'd9);
    add_event(EV_LONG, 4'd0);
    add_event(EV_LONG, KEY_SHIFT);
    add_event(EV_LONG, KEY_NONE);
    add_event(EV_LONG, 4'd15);
    add_event(EV_SHORT, KEY_NONE);
    add_event(EV_SHORT, 4'd15);
    add_event(EV_UNUSED, 4'd5);
    add_event(EV_TICK, 4'd7);
    add_event(EV_SHORT, KEY_SHIFT);
    add_event(EV_SHORT, 4'd9);
    add_event(EV_SHORT, KEY_SHIFT);
    add_event(EV_SHORT, 4'd5);
    add_event(EV_SHORT, KEY_SHIFT);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      tx_idle_pct = (p < 3) ? 25 : (p < 6) ? 77 : 0;
      rx_stall_pct = (p < 3) ? 77 : (p < 6) ? 25 : 0;
      write_reg(CFG_COMMIT_TICKS, PH_TICKS[p]);
      write_reg(CFG_START_LENGTH, PH_START[p]);
      write_reg(CFG_MAX_LENGTH, PH_MAX[p]);
      @(negedge clk_i);
      counted = 0;
      while (counted < PHASE_ITEMS) counted += queue_burst();
      if (p == 0 || p == 3) long_hold_arm = 1'b1;
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Run covered %0d key events over %0d register settings, with stalls on both sides.",
             events_taken, N_PHASES + 1);
    $display("Edits seen: %0d appends, %0d replacements, %0d deletions, %0d without edit.",
             action_cnt[ACT_APPEND], action_cnt[ACT_REPLACE], action_cnt[ACT_DELETE],
             action_cnt[ACT_NONE]);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mtkte_pkg.sv
hw/rtl/multitap_keypad_text_entry.sv
verif/tb_multitap_keypad_text_entry.sv
